FILE: hdl/fcvs_pkg.sv
// Shared types and codes for the fixed-capacity value set.
package fcvs_pkg;

  localparam int unsigned ITEM_W  = 32;
  localparam int unsigned INDEX_W = 5;
  localparam int unsigned COUNT_W = 6;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_ERASE    = 2'd1,
    OP_CONTAINS = 2'd2,
    OP_GET      = 2'd3
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [ITEM_W-1:0]  item_value;
    logic [INDEX_W-1:0] index;
  } in_word_t;

  typedef struct packed {
    logic               ok;
    logic [ITEM_W-1:0]  read_value;
    logic [COUNT_W-1:0] count;
  } out_word_t;

  // Per-cycle commands broadcast to every cell.
  typedef struct packed {
    logic cmp_en;
    logic ins_en;
    logic ers_en;
  } cell_ctrl_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

endpackage

FILE: hdl/fcvs_cell.sv
// One storage cell of the set: holds an entry, compares it, shifts from its neighbor.
module fcvs_cell #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned CNT_W      = 6,
  parameter int unsigned IDX        = 0
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  fcvs_pkg::cell_ctrl_t           ctrl,
  input  logic [VALUE_BITS-1:0]          key,
  input  logic [CNT_W-1:0]               count,
  input  logic [fcvs_pkg::INDEX_W-1:0]   get_idx,
  input  logic [VALUE_BITS-1:0]          next_value,
  input  logic                           seen_in,
  output logic [VALUE_BITS-1:0]          value,
  output logic                           seen_out,
  output logic                           hit,
  output logic [VALUE_BITS-1:0]          rd
);

  localparam logic [CNT_W-1:0] POS      = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] POS_NEXT = CNT_W'(IDX + 1);
  localparam logic [31:0]      POS_32   = 32'(IDX);

  logic [VALUE_BITS-1:0] value_r;
  logic [VALUE_BITS-1:0] value_nxt;
  logic                  hit_r;
  logic                  hit_nxt;
  logic                  occupied;
  logic                  sel;

  assign occupied = POS < count;
  assign sel      = occupied && (32'(get_idx) == POS_32);
  // a match here or below means this cell takes its upper neighbor on erase
  assign seen_out = seen_in | hit_r;
  assign value    = value_r;
  assign hit      = hit_r;
  assign rd       = sel ? value_r : '0;

  always_comb begin
    hit_nxt   = hit_r;
    value_nxt = value_r;
    if (ctrl.cmp_en) begin
      hit_nxt = occupied && (value_r == key);
    end
    if (ctrl.ins_en && (POS == count)) begin
      value_nxt = key;
    end else if (ctrl.ers_en && seen_out && (POS_NEXT < count)) begin
      value_nxt = next_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

FILE: hdl/fixed_capacity_value_set_unit.sv
// Top level of the fixed-capacity value set: cell row, sequencer and result register.
// Holds up to CAPACITY distinct values in insertion order. A word is handled in
// the idle and execute states: in the accept cycle every cell compares its entry
// with the key and registers a hit flag; in the execute state, once the output
// register is free, the hits are combined, the row is updated (insert writes
// the cell at the count, erase shifts every cell above the hit down by one
// through the neighbor links) and the result is loaded into the output
// register, and no new word is taken until then. A stalled result holds the
// sequencer in its execute step. Entries need no clearing after reset; only
// cells below the count are ever read.
module fixed_capacity_value_set_unit #(
  parameter int unsigned CAPACITY   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fcvs_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fcvs_pkg::out_word_t out_data
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  fcvs_pkg::state_t                 state_r, state_nxt;
  fcvs_pkg::op_t                    op_r;
  logic [VALUE_BITS-1:0]            key_r;
  logic [fcvs_pkg::INDEX_W-1:0]     idx_r;
  logic [CNT_W-1:0]                 count_r, count_nxt;
  logic                             out_valid_r, out_valid_nxt;
  fcvs_pkg::out_word_t              out_data_r, out_data_nxt;

  fcvs_pkg::cell_ctrl_t             ctrl;
  logic [VALUE_BITS-1:0]            key;
  logic [VALUE_BITS-1:0]            in_key;
  logic [63:0]                      in_ext;
  logic [63:0]                      rd_ext;
  logic                             accept;
  logic                             go;
  logic                             found;
  logic                             full;
  logic                             ok;
  logic                             get_ok;
  logic [VALUE_BITS-1:0]            rd_or;

  logic [VALUE_BITS-1:0]            cell_val  [CAPACITY];
  logic [VALUE_BITS-1:0]            cell_rd   [CAPACITY];
  logic [CAPACITY-1:0]              cell_hit;
  logic [CAPACITY:0]                seen;

  assign in_ext = 64'(in_data.item_value);
  assign in_key = in_ext[VALUE_BITS-1:0];

  assign accept = in_valid && in_ready;
  assign go     = (state_r == fcvs_pkg::ST_EXEC) && (!out_valid_r || out_ready);
  assign key    = (state_r == fcvs_pkg::ST_IDLE) ? in_key : key_r;

  assign found  = |cell_hit;
  assign full   = (count_r == CNT_FULL);
  assign get_ok = 32'(idx_r) < 32'(count_r);
  assign seen[0] = 1'b0;

  always_comb begin
    rd_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_or = rd_or | cell_rd[i];
    end
  end

  assign rd_ext = 64'(rd_or);

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    fcvs_cell #(
      .VALUE_BITS (VALUE_BITS),
      .CNT_W      (CNT_W),
      .IDX        (k)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .key        (key),
      .count      (count_r),
      .get_idx    (idx_r),
      .next_value ((k + 1 < CAPACITY) ? cell_val[(k + 1) % CAPACITY] : '0),
      .seen_in    (seen[k]),
      .value      (cell_val[k]),
      .seen_out   (seen[k+1]),
      .hit        (cell_hit[k]),
      .rd         (cell_rd[k])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ctrl          = '0;
    ok            = 1'b0;
    in_ready      = 1'b0;

    case (state_r)
      fcvs_pkg::ST_IDLE: begin
        // ready is always high here, so valid alone marks the accept
        in_ready    = 1'b1;
        ctrl.cmp_en = in_valid;
        if (in_valid) begin
          state_nxt = fcvs_pkg::ST_EXEC;
        end
      end
      fcvs_pkg::ST_EXEC: begin
        case (op_r)
          fcvs_pkg::OP_INSERT:   ok = !found && !full;
          fcvs_pkg::OP_ERASE:    ok = found;
          fcvs_pkg::OP_CONTAINS: ok = found;
          fcvs_pkg::OP_GET:      ok = get_ok;
          default:               ok = 1'b0;
        endcase
        if (go) begin
          ctrl.ins_en = (op_r == fcvs_pkg::OP_INSERT) && ok;
          ctrl.ers_en = (op_r == fcvs_pkg::OP_ERASE) && ok;
          if (ctrl.ins_en) begin
            count_nxt = count_r + CNT_ONE;
          end else if (ctrl.ers_en) begin
            count_nxt = count_r - CNT_ONE;
          end
          out_valid_nxt         = 1'b1;
          out_data_nxt.ok       = ok;
          out_data_nxt.read_value = ((op_r == fcvs_pkg::OP_GET) && ok) ?
                                    rd_ext[fcvs_pkg::ITEM_W-1:0] : '0;
          out_data_nxt.count    = fcvs_pkg::COUNT_W'(32'(count_nxt));
          state_nxt             = fcvs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fcvs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fcvs_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (accept) begin
      op_r  <= in_data.op;
      key_r <= in_key;
      idx_r <= in_data.index;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
